[hw/rtl/tcd_pkg.sv]
package tcd_pkg;

    localparam int TCD_ROWS = 25;
    localparam int TCD_COLS = 80;

    // Access kinds.
    localparam logic [1:0] MODE_CTRL = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Control codes accepted while no command is pending.
    localparam logic [7:0] CMD_CLEAR  = 8'd2;
    localparam logic [7:0] CMD_ATTR   = 8'd3;
    localparam logic [7:0] CMD_CURSOR = 8'd4;

    // Command states as reported in the pending field.
    localparam logic [1:0] PEND_IDLE = 2'd0;
    localparam logic [1:0] PEND_ATTR = 2'd1;
    localparam logic [1:0] PEND_ROW  = 2'd2;
    localparam logic [1:0] PEND_COL  = 2'd3;

    // Character codes.
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam logic [7:0] ATTR_RESET = 8'h0f;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic [4:0] view_row;
        logic [6:0] view_col;
    } req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [4:0] scroll_top;
        logic [1:0] pending;
    } resp_t;

    // Strobes from the sequencer to the cell store.
    typedef struct packed {
        logic wr;
        logic rd;
    } ram_cmd_t;

endpackage

[hw/rtl/tcd_cell_ram.sv]
module tcd_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                clk,
    input  tcd_pkg::ram_cmd_t   cmd,
    input  logic [AW-1:0]       addr,
    input  logic [15:0]         wdata,
    output logic [15:0]         rdata
);
    import tcd_pkg::*;

    // Each word holds the character in the upper byte and the attribute below.
    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tcd_addr_unit.sv]
module tcd_addr_unit #(
    parameter int COLS = 80,
    parameter int RW   = 5,
    parameter int CW   = 7,
    parameter int AW   = 11
) (
    input  logic          clk,
    input  logic [RW-1:0] row,
    input  logic [CW-1:0] col,
    output logic [AW-1:0] addr
);
    import tcd_pkg::*;

    logic [AW-1:0] addr_reg;

    // Row-major cell index, shared by printing and reading.
    always_ff @(posedge clk)
    begin
        addr_reg <= AW'(32'(row) * COLS + 32'(col));
    end

    assign addr = addr_reg;

endmodule

[hw/rtl/text_console_device.sv]
// Text console with a ROWS x COLS cell store, a cursor, a scroll origin and a
// command decoder. One request is handled at a time and each gives exactly one
// response. Control writes and non-printing data writes go from acceptance
// straight to the response state; printable data writes and cell reads first
// pass the row wrap, as the cell index then passes through the registered
// address multiplier and then the single-port cell store. The clear command
// sweeps the store one cell a cycle and then responds. After reset the store
// is swept to zero, during which req_ready stays low. A new request may be
// accepted while the previous response still waits in the output register.
module text_console_device #(
    parameter int ROWS = tcd_pkg::TCD_ROWS,
    parameter int COLS = tcd_pkg::TCD_COLS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tcd_pkg::req_t  req,
    output logic           resp_valid,
    input  logic           resp_ready,
    output tcd_pkg::resp_t resp
);
    import tcd_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = RW + 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WRAP,
        S_ADDR,
        S_MEM,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [7:0]    attr_reg, attr_next;
    logic [1:0]    pend_reg, pend_next;
    logic [SW-1:0] op_row_reg, op_row_next;
    logic [CW-1:0] op_col_reg, op_col_next;
    logic [7:0]    op_char_reg, op_char_next;
    logic          op_wr_reg, op_wr_next;
    logic          op_rd_reg, op_rd_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          resp_valid_reg, resp_valid_next;
    resp_t         resp_reg, resp_next;

    logic          accept;
    logic [RW-1:0] nl_row;
    logic [RW-1:0] nl_top;
    logic [RW-1:0] view_row_c;
    logic [CW-1:0] view_col_c;
    logic [AW-1:0] unit_addr;
    ram_cmd_t      ram_cmd;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // Cursor position after a move to the next line; the display scrolls on
    // wrapping past the last row.
    always_comb
    begin
        nl_row = cur_row_reg + RW'(1);
        nl_top = top_reg;
        if (32'(cur_row_reg) == ROWS - 1)
        begin
            nl_row = '0;
            nl_top = (32'(top_reg) == ROWS - 1) ? '0 : top_reg + RW'(1);
        end
    end

    assign view_row_c = (32'(req.view_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(req.view_row);
    assign view_col_c = (32'(req.view_col) > COLS - 1) ? CW'(COLS - 1) : CW'(req.view_col);

    always_comb
    begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        attr_next       = attr_reg;
        pend_next       = pend_reg;
        op_row_next     = op_row_reg;
        op_col_next     = op_col_reg;
        op_char_next    = op_char_reg;
        op_wr_next      = op_wr_reg;
        op_rd_next      = op_rd_reg;
        clr_cnt_next    = clr_cnt_reg;
        resp_valid_next = resp_valid_reg && !resp_ready;
        resp_next       = resp_reg;
        ram_cmd         = '0;
        ram_addr        = unit_addr;
        ram_wdata       = {op_char_reg, attr_reg};

        case (state_reg)
            S_INIT:
            begin
                ram_cmd.wr   = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == CELLS - 1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    op_wr_next = 1'b0;
                    op_rd_next = 1'b0;
                    state_next = S_DONE;
                    case (req.mode)
                        MODE_CTRL:
                        begin
                            case (pend_reg)
                                PEND_ATTR:
                                begin
                                    attr_next = req.value;
                                    pend_next = PEND_IDLE;
                                end
                                PEND_ROW:
                                begin
                                    cur_row_next = (32'(req.value) > ROWS - 1)
                                                   ? RW'(ROWS - 1) : RW'(req.value);
                                    pend_next    = PEND_COL;
                                end
                                PEND_COL:
                                begin
                                    cur_col_next = (32'(req.value) > COLS - 1)
                                                   ? CW'(COLS - 1) : CW'(req.value);
                                    pend_next    = PEND_IDLE;
                                end
                                default:
                                begin
                                    if (req.value == CMD_CLEAR)
                                    begin
                                        top_next     = '0;
                                        clr_cnt_next = '0;
                                        state_next   = S_CLEAR;
                                    end
                                    else if (req.value == CMD_ATTR)
                                    begin
                                        pend_next = PEND_ATTR;
                                    end
                                    else if (req.value == CMD_CURSOR)
                                    begin
                                        pend_next = PEND_ROW;
                                    end
                                end
                            endcase
                        end

                        MODE_DATA:
                        begin
                            if (req.value >= CHAR_BLANK && req.value < CHAR_DEL)
                            begin
                                // The cell address is taken from the cursor
                                // before it advances.
                                op_row_next  = {1'b0, cur_row_reg};
                                op_col_next  = cur_col_reg;
                                op_char_next = req.value;
                                op_wr_next   = 1'b1;
                                state_next   = S_WRAP;
                                if (32'(cur_col_reg) >= COLS - 1)
                                begin
                                    cur_col_next = '0;
                                    cur_row_next = nl_row;
                                    top_next     = nl_top;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + CW'(1);
                                end
                            end
                            else if (req.value == CHAR_LF)
                            begin
                                cur_col_next = '0;
                                cur_row_next = nl_row;
                                top_next     = nl_top;
                            end
                            else if (req.value == CHAR_CR)
                            begin
                                cur_col_next = '0;
                            end
                        end

                        MODE_READ:
                        begin
                            op_row_next = SW'(view_row_c) + SW'(top_reg);
                            op_col_next = view_col_c;
                            op_rd_next  = 1'b1;
                            state_next  = S_WRAP;
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WRAP:
            begin
                // The displayed row plus the origin stays below twice ROWS.
                if (op_row_reg >= SW'(ROWS))
                begin
                    op_row_next = op_row_reg - SW'(ROWS);
                end
                state_next = S_ADDR;
            end

            S_ADDR:
            begin
                state_next = S_MEM;
            end

            S_MEM:
            begin
                ram_cmd.wr = op_wr_reg;
                ram_cmd.rd = op_rd_reg;
                state_next = S_DONE;
            end

            S_CLEAR:
            begin
                ram_cmd.wr   = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = {CHAR_BLANK, attr_reg};
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == CELLS - 1)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!resp_valid_reg || resp_ready)
                begin
                    resp_valid_next      = 1'b1;
                    resp_next.cell_char  = op_rd_reg ? ram_rdata[15:8] : 8'd0;
                    resp_next.cell_attr  = op_rd_reg ? ram_rdata[7:0] : 8'd0;
                    resp_next.cursor_row = 5'(cur_row_reg);
                    resp_next.cursor_col = 7'(cur_col_reg);
                    resp_next.scroll_top = 5'(top_reg);
                    resp_next.pending    = pend_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            pend_reg       <= PEND_IDLE;
            op_row_reg     <= '0;
            op_col_reg     <= '0;
            op_char_reg    <= '0;
            op_wr_reg      <= 1'b0;
            op_rd_reg      <= 1'b0;
            clr_cnt_reg    <= '0;
            resp_valid_reg <= 1'b0;
            resp_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            attr_reg       <= attr_next;
            pend_reg       <= pend_next;
            op_row_reg     <= op_row_next;
            op_col_reg     <= op_col_next;
            op_char_reg    <= op_char_next;
            op_wr_reg      <= op_wr_next;
            op_rd_reg      <= op_rd_next;
            clr_cnt_reg    <= clr_cnt_next;
            resp_valid_reg <= resp_valid_next;
            resp_reg       <= resp_next;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    tcd_addr_unit #(
        .COLS (COLS),
        .RW   (RW),
        .CW   (CW),
        .AW   (AW)
    ) u_addr (
        .clk  (clk),
        .row  (op_row_reg[RW-1:0]),
        .col  (op_col_reg),
        .addr (unit_addr)
    );

    tcd_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .cmd   (ram_cmd),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

[hw/rtl/tcd_checker.sv]
module tcd_checker #(
    parameter int ROWS = tcd_pkg::TCD_ROWS,
    parameter int COLS = tcd_pkg::TCD_COLS
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input tcd_pkg::req_t  req,
    input logic           resp_valid,
    input logic           resp_ready,
    input tcd_pkg::resp_t resp
);
    import tcd_pkg::*;

    // A waiting request keeps its payload until it is taken.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request dropped or changed before it was taken");

    // A response that is not taken stays on the port unchanged.
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp))
        else $error("response dropped or changed while stalled");

    // Only one request is in progress at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> 32'(resp.cursor_col) < COLS)
        else $error("cursor column beyond the last column");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> 32'(resp.cursor_row) < ROWS && 32'(resp.scroll_top) < ROWS)
        else $error("cursor row or scroll origin beyond the last row");

endmodule

bind text_console_device tcd_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
);

[tb/tb_text_console_device.sv]
`timescale 1ns / 1ps

module tb_text_console_device;

    import tcd_pkg::*;

    localparam int ROWS  = TCD_ROWS;
    localparam int COLS  = TCD_COLS;
    localparam int CELLS = ROWS * COLS;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;

    // Codes that the decoder must pass over without effect.
    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam logic [7:0] CMD_NOP     = 8'd0;
    localparam logic [7:0] CMD_SUSPEND = 8'd1;

    typedef struct {
        req_t  rq;
        bit    fixed;
        resp_t want;
    } step_row_t;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  resp_valid;
    logic  resp_ready;
    resp_t resp;

    // Shadow copy of the console.
    logic [7:0] screen_char [CELLS];
    logic [7:0] screen_attr [CELLS];
    int         cur_row;
    int         cur_col;
    int         top_row;
    logic [7:0] pen_attr;
    logic [1:0] cmd_pend;

    resp_t     predicted_resp_q[$];
    step_row_t directed_q[$];

    int  access_count = 0;
    int  mismatches = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    bit  burst = 1'b0;
    bit  hold_ask = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;

    text_console_device uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void advance_line();
        cur_col = 0;
        if (cur_row >= ROWS - 1)
        begin
            cur_row = 0;
            top_row = (top_row + 1) % ROWS;
        end
        else
        begin
            cur_row++;
        end
    endfunction

    function automatic resp_t console_step(input req_t r);
        resp_t o;
        int    vr;
        int    vc;
        int    ix;
        o = '0;
        case (r.mode)
            MODE_CTRL:
            begin
                case (cmd_pend)
                    PEND_ATTR:
                    begin
                        pen_attr = r.value;
                        cmd_pend = PEND_IDLE;
                    end
                    PEND_ROW:
                    begin
                        cur_row  = (r.value > ROWS - 1) ? ROWS - 1 : int'(r.value);
                        cmd_pend = PEND_COL;
                    end
                    PEND_COL:
                    begin
                        cur_col  = (r.value > COLS - 1) ? COLS - 1 : int'(r.value);
                        cmd_pend = PEND_IDLE;
                    end
                    default:
                    begin
                        if (r.value == CMD_CLEAR)
                        begin
                            for (ix = 0; ix < CELLS; ix++)
                            begin
                                screen_char[ix] = CHAR_BLANK;
                                screen_attr[ix] = pen_attr;
                            end
                            top_row = 0;
                        end
                        else if (r.value == CMD_ATTR)
                        begin
                            cmd_pend = PEND_ATTR;
                        end
                        else if (r.value == CMD_CURSOR)
                        begin
                            cmd_pend = PEND_ROW;
                        end
                    end
                endcase
            end
            MODE_DATA:
            begin
                if (r.value >= CHAR_BLANK && r.value < CHAR_DEL)
                begin
                    ix = cur_row * COLS + cur_col;
                    screen_char[ix] = r.value;
                    screen_attr[ix] = pen_attr;
                    if (cur_col >= COLS - 1)
                        advance_line();
                    else
                        cur_col++;
                end
                else if (r.value == CHAR_LF)
                begin
                    advance_line();
                end
                else if (r.value == CHAR_CR)
                begin
                    cur_col = 0;
                end
            end
            MODE_READ:
            begin
                vr = (r.view_row > ROWS - 1) ? ROWS - 1 : int'(r.view_row);
                vc = (r.view_col > COLS - 1) ? COLS - 1 : int'(r.view_col);
                ix = ((vr + top_row) % ROWS) * COLS + vc;
                o.cell_char = screen_char[ix];
                o.cell_attr = screen_attr[ix];
            end
            default: ;
        endcase
        o.cursor_row = 5'(cur_row);
        o.cursor_col = 7'(cur_col);
        o.scroll_top = 5'(top_row);
        o.pending    = cmd_pend;
        return o;
    endfunction

    function automatic req_t rand_req(input logic [1:0] m, input logic [7:0] v);
        req_t r;
        r.mode     = m;
        r.value    = v;
        r.view_row = 5'($urandom);
        r.view_col = 7'($urandom);
        return r;
    endfunction

    task automatic add_row(input req_t r, input bit fixed, input resp_t want);
        step_row_t s;
        s.rq    = r;
        s.fixed = fixed;
        s.want  = want;
        directed_q.push_back(s);
    endtask

    task automatic send_req(input req_t r, input bit fixed, input resp_t want);
        resp_t p;
        while (!burst && $urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        p = console_step(r);
        predicted_resp_q.push_back(fixed ? want : p);
    endtask

    task automatic send_counted(input req_t r);
        send_req(r, 1'b0, '0);
        access_count++;
    endtask

    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return CHAR_LF;
        else if (pick == 1)
            return CHAR_CR;
        return 8'($urandom_range(126, 32));
    endfunction

    function automatic req_t read_req();
        req_t r;
        r = rand_req(MODE_READ, 8'($urandom));
        if ($urandom_range(4) != 0)
        begin
            r.view_row = 5'($urandom_range(ROWS - 1));
            r.view_col = 7'($urandom_range(COLS - 1));
        end
        return r;
    endfunction

    task automatic random_sequence();
        int   kind;
        int   n;
        req_t r;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            n = $urandom_range(12, 1);
            repeat (n)
                send_counted(rand_req(MODE_DATA, text_byte()));
        end
        else if (kind < 50)
        begin
            send_counted(rand_req(MODE_CTRL, CMD_ATTR));
            send_counted(rand_req(MODE_CTRL, 8'($urandom)));
        end
        else if (kind < 62)
        begin
            send_counted(rand_req(MODE_CTRL, CMD_CURSOR));
            n = $urandom_range(9);
            r = rand_req(MODE_CTRL, (n < 7) ? 8'($urandom_range(ROWS - 1)) :
                         (n == 7) ? 8'(ROWS - 1) : 8'($urandom));
            send_counted(r);
            n = $urandom_range(9);
            r = rand_req(MODE_CTRL, (n < 7) ? 8'($urandom_range(COLS - 1)) :
                         (n == 7) ? 8'(COLS - 1) : 8'($urandom));
            send_counted(r);
        end
        else if (kind < 84)
        begin
            n = $urandom_range(6, 1);
            repeat (n)
                send_counted(read_req());
        end
        else if (kind < 86)
        begin
            send_counted(rand_req(MODE_CTRL, CMD_CLEAR));
        end
        else if (kind < 93)
        begin
            // A command interrupted by data writes and reads, completed only sometimes.
            send_counted(rand_req(MODE_CTRL, $urandom_range(1) ? CMD_ATTR : CMD_CURSOR));
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                if ($urandom_range(1))
                    send_counted(rand_req(MODE_DATA, text_byte()));
                else
                    send_counted(read_req());
            end
            if ($urandom_range(1))
                send_counted(rand_req(MODE_CTRL, 8'($urandom)));
        end
        else
        begin
            // Noise: any mode and any byte, not counted towards the request budget.
            n = $urandom_range(3, 1);
            repeat (n)
                send_req(rand_req(2'($urandom), 8'($urandom)), 1'b0, '0);
        end
    endtask

    // Response checker and receiver-side stalling.
    initial
    begin
        resp_t e;
        resp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (resp_valid && resp_ready)
            begin
                if (predicted_resp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected response at %0t: %p", $realtime, resp);
                end
                else
                begin
                    e = predicted_resp_q.pop_front();
                    if (resp.cell_char !== e.cell_char || resp.cell_attr !== e.cell_attr ||
                        resp.cursor_row !== e.cursor_row ||
                        resp.cursor_col !== e.cursor_col ||
                        resp.scroll_top !== e.scroll_top || resp.pending !== e.pending)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch at %0t: expected %p, got %p",
                                     $realtime, e, resp);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                resp_ready <= 1'b0;
            end
            else if (hold_ask)
            begin
                hold_ask   = 1'b0;
                hold_left  = HOLD_CYCLES;
                resp_ready <= 1'b0;
            end
            else
            begin
                resp_ready <= burst || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        int phase;
        int target;
        bit hold_done;
        int gaps   [4] = '{0, 58, 0, 21};
        int stalls [4] = '{0, 0, 58, 21};
        hold_done = 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // After reset the store is all zero, with the cursor home and nothing pending.
        add_row(req_t'{MODE_READ, 8'h00, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_READ, 8'hff, 5'd31, 7'd127}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_NONE, 8'hff, 5'd31, 7'd127}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_CTRL, CMD_NOP, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_CTRL, CMD_SUSPEND, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_CTRL, 8'hff, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_DATA, 8'h1f, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_DATA, CHAR_DEL, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_DATA, 8'hff, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_CTRL, CMD_ATTR, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd0, PEND_ATTR});
        // A printable byte while the attribute is awaited leaves the command pending.
        add_row(req_t'{MODE_DATA, 8'h41, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd1, 5'd0, PEND_ATTR});
        add_row(req_t'{MODE_CTRL, 8'ha5, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd1, 5'd0, PEND_IDLE});
        add_row(req_t'{MODE_CTRL, CMD_CURSOR, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd1, 5'd0, PEND_ROW});
        add_row(req_t'{MODE_CTRL, 8'hff, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd24, 7'd1, 5'd0, PEND_COL});
        add_row(req_t'{MODE_CTRL, 8'hff, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd24, 7'd79, 5'd0, PEND_IDLE});
        // The last cell: the cursor wraps to the top and the display scrolls.
        add_row(req_t'{MODE_DATA, 8'h7e, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd0, 7'd0, 5'd1, PEND_IDLE});
        add_row(req_t'{MODE_DATA, CHAR_LF, 5'd0, 7'd0}, 1'b1,
                resp_t'{8'h00, 8'h00, 5'd1, 7'd0, 5'd1, PEND_IDLE});
        add_row(req_t'{MODE_DATA, CHAR_BLANK, 5'd0, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_DATA, CHAR_CR, 5'd0, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_READ, 8'h00, 5'd23, 7'd79}, 1'b0, '0);
        add_row(req_t'{MODE_READ, 8'h00, 5'd24, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_CTRL, CMD_CLEAR, 5'd0, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_READ, 8'h00, 5'd31, 7'd127}, 1'b0, '0);
        add_row(req_t'{MODE_CTRL, CMD_CURSOR, 5'd0, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_CTRL, 8'h00, 5'd0, 7'd0}, 1'b0, '0);
        add_row(req_t'{MODE_CTRL, 8'h00, 5'd0, 7'd0}, 1'b0, '0);

        for (int i = 0; i < CELLS; i++)
        begin
            screen_char[i] = 8'h00;
            screen_attr[i] = 8'h00;
        end
        cur_row  = 0;
        cur_col  = 0;
        top_row  = 0;
        pen_attr = ATTR_RESET;
        cmd_pend = PEND_IDLE;

        @(posedge rst_n);
        foreach (directed_q[i])
            send_req(directed_q[i].rq, directed_q[i].fixed, directed_q[i].want);

        for (phase = 0; phase < 4; phase++)
        begin
            gap_pct   = gaps[phase];
            stall_pct = stalls[phase];
            target    = (phase + 1) * RANDOM_ITEMS / 4;
            while (access_count < target)
            begin
                // Hold the receiver off for a long stretch while requests keep coming.
                if (!hold_done && access_count >= 150)
                begin
                    hold_ask  = 1'b1;
                    hold_done = 1'b1;
                end
                burst = ($urandom_range(9) == 0);
                random_sequence();
            end
        end
        burst = 1'b0;
        req_valid <= 1'b0;

        while (predicted_resp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && predicted_resp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
